[rtl/dda_pkg.sv]
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared types and codes for the line rasterizer and its port checker.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_W    = 16;   // endpoint coordinate, signed 1/16 px
    localparam int SCR_W      = 10;   // screen coordinate on the pixel port
    localparam int COLOR_W    = 24;
    localparam int PTS_W      = 13;   // number of points left on the line
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [SCR_W-1:0]   ORIGIN_RST = 10'd512;
    localparam logic [COLOR_W-1:0] COLOR_RST  = 24'hFFFFFF;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COLOR = 2'd2;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_PREP,
        ST_DIV_X,
        ST_DIV_Y
    } state_t;

endpackage

[rtl/dda_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Loads a line, works out per-pixel increments with a shared restoring
// divider, then steps along the line one pixel per tick transaction.
// ----------------------------------------------------------------------------
// Tick: one transaction per cycle; the pixel appears on the output register
//   in the cycle after the tick is taken.
// Load: input stalls for 2*FRAC_BITS+3 cycles after acceptance (one set-up
//   cycle, then FRAC_BITS+1 divider steps for x and again for y), or for one
//   cycle on a zero-length line. The single divider subtractor sets this.
// Reset (rst_n low, asynchronous): line idle, origin 512/512, colour white.
// ----------------------------------------------------------------------------
module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int WIN_W     = 1024,
    parameter int WIN_H     = 1024,
    parameter int FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [COORD_W-1:0]    start_x,
    input  logic [COORD_W-1:0]    start_y,
    input  logic [COORD_W-1:0]    end_x,
    input  logic [COORD_W-1:0]    end_y,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SCR_W-1:0]      pixel_x,
    output logic [SCR_W-1:0]      pixel_y,
    output logic [COLOR_W-1:0]    pixel_color,
    output logic                  last_pixel
);

    localparam int DIFF_W = COORD_W + 1;          // endpoint difference
    localparam int POS_W  = FRAC_BITS + 14;       // position, signed fixed point
    localparam int STEP_W = FRAC_BITS + 2;        // increment, |step| <= 1.0
    localparam int SPOS_W = FRAC_BITS + 15;       // screen position
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int REM_W  = COORD_W + 1;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);

    localparam logic signed [SPOS_W-1:0] WIN_X_LIM = SPOS_W'(WIN_W) << FRAC_BITS;
    localparam logic signed [SPOS_W-1:0] WIN_Y_LIM = SPOS_W'(WIN_H) << FRAC_BITS;

    state_t                     state_reg, state_next;
    logic signed [DIFF_W-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic signed [POS_W-1:0]    pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [STEP_W-1:0]   step_x_reg, step_x_next, step_y_reg, step_y_next;
    logic [PTS_W-1:0]           points_reg, points_next;
    logic                       active_reg, active_next;
    logic [COORD_W-1:0]         mag_y_reg, mag_y_next;
    logic                       neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [COORD_W-1:0]         div_s_reg, div_s_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [QUO_W-1:0]           quo_reg, quo_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;

    logic [SCR_W-1:0]           origin_x_reg, origin_y_reg;
    logic [COLOR_W-1:0]         color_reg;

    logic                       out_valid_reg, out_valid_next;
    logic [SCR_W-1:0]           pixel_x_reg, pixel_x_next, pixel_y_reg, pixel_y_next;
    logic [COLOR_W-1:0]         pixel_color_reg, pixel_color_next;
    logic                       last_reg, last_next;

    logic                       in_take;
    logic [DIFF_W-1:0]          abs_x, abs_y;
    logic [COORD_W-1:0]         span;
    logic [REM_W-1:0]           rem_shift;
    logic [REM_W:0]             rem_diff;
    logic                       rem_ge;
    logic [QUO_W-1:0]           quo_new;
    logic signed [STEP_W-1:0]   step_new;
    logic signed [SPOS_W-1:0]   scr_x, scr_y;
    logic                       outside;
    logic                       last_point;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= ORIGIN_RST;
            origin_y_reg <= ORIGIN_RST;
            color_reg    <= COLOR_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ORIGIN_X:   origin_x_reg <= wr_data[SCR_W-1:0];
                REG_ORIGIN_Y:   origin_y_reg <= wr_data[SCR_W-1:0];
                REG_LINE_COLOR: color_reg    <= wr_data[COLOR_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---------------------------------------------------------------- shared divider step
    always_comb
    begin
        // the first step compares the magnitude itself, later ones shift a zero in
        rem_shift = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
        rem_diff  = {1'b0, rem_shift} - {2'b00, div_s_reg};
        rem_ge    = !rem_diff[REM_W];
        quo_new   = {quo_reg[QUO_W-2:0], rem_ge};
        if (state_reg == ST_DIV_X ? neg_x_reg : neg_y_reg)
            step_new = -$signed({1'b0, quo_new});
        else
            step_new = $signed({1'b0, quo_new});
    end

    // ---------------------------------------------------------------- tick datapath
    assign abs_x = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
    assign abs_y = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
    assign span  = (abs_x > abs_y) ? abs_x[COORD_W-1:0] : abs_y[COORD_W-1:0];

    assign scr_x = $signed(SPOS_W'(origin_x_reg) << FRAC_BITS) + SPOS_W'(pos_x_reg);
    assign scr_y = $signed(SPOS_W'(origin_y_reg) << FRAC_BITS) - SPOS_W'(pos_y_reg);
    assign outside = scr_x[SPOS_W-1] || (scr_x >= WIN_X_LIM)
                  || scr_y[SPOS_W-1] || (scr_y >= WIN_Y_LIM);
    assign last_point = (points_reg <= PTS_W'(1));

    assign in_stall = (state_reg != ST_RUN) || (out_valid_reg && out_stall);
    assign in_take  = in_valid && !in_stall;

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next       = state_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        step_x_next      = step_x_reg;
        step_y_next      = step_y_reg;
        points_next      = points_reg;
        active_next      = active_reg;
        mag_y_next       = mag_y_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;
        div_s_next       = div_s_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && out_stall;
        pixel_x_next     = pixel_x_reg;
        pixel_y_next     = pixel_y_reg;
        pixel_color_next = pixel_color_reg;
        last_next        = last_reg;

        case (state_reg)
            ST_RUN:
            begin
                if (in_take && func == FUNC_LOAD)
                begin
                    // drop any line in progress
                    dx_next     = $signed(DIFF_W'($signed(end_x)))
                                - $signed(DIFF_W'($signed(start_x)));
                    dy_next     = $signed(DIFF_W'($signed(end_y)))
                                - $signed(DIFF_W'($signed(start_y)));
                    pos_x_next  = POS_W'($signed(start_x)) <<< (FRAC_BITS - 4);
                    pos_y_next  = POS_W'($signed(start_y)) <<< (FRAC_BITS - 4);
                    active_next = 1'b0;
                    state_next  = ST_PREP;
                end
                else if (in_take && func == FUNC_TICK && active_reg)
                begin
                    if (outside)
                    begin
                        active_next = 1'b0;
                        points_next = '0;
                    end
                    else
                    begin
                        out_valid_next   = 1'b1;
                        pixel_x_next     = scr_x[FRAC_BITS +: SCR_W];
                        pixel_y_next     = scr_y[FRAC_BITS +: SCR_W];
                        pixel_color_next = color_reg;
                        last_next        = last_point;
                        if (last_point)
                        begin
                            points_next = '0;
                            active_next = 1'b0;
                        end
                        else
                        begin
                            points_next = points_reg - PTS_W'(1);
                        end
                        pos_x_next = pos_x_reg + POS_W'(step_x_reg);
                        pos_y_next = pos_y_reg + POS_W'(step_y_reg);
                    end
                end
            end

            ST_PREP:
            begin
                points_next = PTS_W'(span[COORD_W-1:4]) + PTS_W'(1);
                neg_x_next  = dx_reg[DIFF_W-1];
                neg_y_next  = dy_reg[DIFF_W-1];
                mag_y_next  = abs_y[COORD_W-1:0];
                if (span == '0)
                begin
                    step_x_next = '0;
                    step_y_next = '0;
                    active_next = 1'b1;
                    state_next  = ST_RUN;
                end
                else
                begin
                    div_s_next = span;
                    rem_next   = REM_W'(abs_x[COORD_W-1:0]);
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV_X;
                end
            end

            ST_DIV_X:
            begin
                rem_next = rem_ge ? rem_diff[REM_W-1:0] : rem_shift;
                quo_next = quo_new;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FRAC_BITS))
                begin
                    step_x_next = step_new;
                    rem_next    = REM_W'(mag_y_reg);
                    quo_next    = '0;
                    cnt_next    = '0;
                    state_next  = ST_DIV_Y;
                end
            end

            ST_DIV_Y:
            begin
                rem_next = rem_ge ? rem_diff[REM_W-1:0] : rem_shift;
                quo_next = quo_new;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FRAC_BITS))
                begin
                    step_y_next = step_new;
                    active_next = 1'b1;
                    state_next  = ST_RUN;
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            active_reg    <= 1'b0;
            points_reg    <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            points_reg    <= points_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            step_x_reg    <= step_x_next;
            step_y_reg    <= step_y_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        mag_y_reg       <= mag_y_next;
        neg_x_reg       <= neg_x_next;
        neg_y_reg       <= neg_y_next;
        div_s_reg       <= div_s_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        pixel_x_reg     <= pixel_x_next;
        pixel_y_reg     <= pixel_y_next;
        pixel_color_reg <= pixel_color_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last_pixel  = last_reg;

endmodule

[rtl/dda_checker.sv]
// ----------------------------------------------------------------------------
// DDA line rasterizer port checker
// Watches the top-level ports for handshake and sequencing faults.
// ----------------------------------------------------------------------------
module dda_checker
    import dda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               func,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [SCR_W-1:0]   pixel_x,
    input  logic [SCR_W-1:0]   pixel_y,
    input  logic [COLOR_W-1:0] pixel_color,
    input  logic               last_pixel
);

    logic load_take;
    logic tick_take;

    assign load_take = in_valid && !in_stall && func == FUNC_LOAD;
    assign tick_take = in_valid && !in_stall && func == FUNC_TICK;

    // hold a stalled pixel
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(pixel_color) && $stable(last_pixel))
        else $error("stalled pixel transaction changed");

    // a load keeps the input stalled while increments are worked out
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load_take |=> in_stall)
        else $error("input taken during line set-up");

    // a fresh pixel only follows a tick transaction
    a_pixel_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(tick_take))
        else $error("pixel without a tick");

    // a load never produces a pixel
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        load_take && !(out_valid && out_stall) |=> !out_valid)
        else $error("pixel produced by a load");

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (.*);
